FILE: sv/vdi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex deduplication indexer package
// Shared constants and the control word that travels along the cell chain.
// ----------------------------------------------------------------------------
package vdi_pkg;

	localparam int VDI_TABLE_DEPTH = 1024;
	localparam int VDI_WORD_W      = 32;
	localparam int VDI_VTX_W       = 8 * VDI_WORD_W;
	localparam int VDI_INDEX_W     = 10;

	typedef struct packed {
		logic valid;
		logic clear;
		logic found;
		logic is_new;
	} vdi_ctl_t;

endpackage
`default_nettype wire

FILE: sv/vertex_dedup_indexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex deduplication indexer
// Returns a stable index for each distinct vertex of a mesh and flags vertices
// that are seen for the first time.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, one entry per cell, and every
// request walks the whole row one cell per cycle unless a stalled result
// holds it. A vertex takes the index of the cell whose entry matches it bit
// for bit, or claims the first empty cell and is marked new; if it reaches
// the end unmatched with no empty cell, the table is full. A request with
// first_of_mesh set claims the first cell and empties every other cell as it
// passes, so later requests see a table holding only its vertex. One vertex
// is accepted every cycle while results are taken. Each result is offered
// from the register of the last cell, after the request has passed through
// the register of every cell. A stalled result holds the whole row.
module vertex_dedup_indexer #(
	parameter int TABLE_DEPTH = vdi_pkg::VDI_TABLE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                vtx_valid,
	output logic                                     vtx_ready,
	input  wire logic                                first_of_mesh,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      pos_x,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      pos_y,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      pos_z,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      tex_u,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      tex_v,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      norm_x,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      norm_y,
	input  wire logic [vdi_pkg::VDI_WORD_W-1:0]      norm_z,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic [vdi_pkg::VDI_INDEX_W-1:0]          vertex_index,
	output logic                                     is_new,
	output logic                                     table_full
);
	import vdi_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	vdi_ctl_t                     chain_ctl [TABLE_DEPTH+1];
	logic [IDX_W-1:0]             chain_idx [TABLE_DEPTH+1];
	logic [VDI_VTX_W-1:0]         chain_vtx [TABLE_DEPTH+1];
	logic                         advance;
	logic [IDX_W+VDI_INDEX_W-1:0] idx_ext;

	assign advance   = !chain_ctl[TABLE_DEPTH].valid || res_ready;
	assign vtx_ready = advance;

	assign chain_ctl[0] = '{valid: vtx_valid, clear: first_of_mesh, found: 1'b0, is_new: 1'b0};
	assign chain_idx[0] = '0;
	assign chain_vtx[0] = {pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z};

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		vdi_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.CELL_IDX    (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.in_ctl  (chain_ctl[g]),
			.in_idx  (chain_idx[g]),
			.in_vtx  (chain_vtx[g]),
			.out_ctl (chain_ctl[g+1]),
			.out_idx (chain_idx[g+1]),
			.out_vtx (chain_vtx[g+1])
		);
	end

	assign idx_ext      = {{VDI_INDEX_W{1'b0}}, chain_idx[TABLE_DEPTH]};
	assign res_valid    = chain_ctl[TABLE_DEPTH].valid;
	assign vertex_index = idx_ext[VDI_INDEX_W-1:0];
	assign is_new       = chain_ctl[TABLE_DEPTH].is_new;
	assign table_full   = !chain_ctl[TABLE_DEPTH].found;

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(is_new && table_full))
		else $error("result flagged both new and table full");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && table_full) |-> (vertex_index == '0))
		else $error("table full result carries a non-zero index");

	a_first_cell_new: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid && vtx_ready && first_of_mesh) |=> chain_ctl[1].is_new)
		else $error("first vertex of a mesh not stored in the first cell");

endmodule
`default_nettype wire

FILE: sv/vdi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex deduplication cell
// Holds one table entry, compares a passing request against it, claims the
// entry for a new vertex, clears it at mesh start and registers the request.
// ----------------------------------------------------------------------------
module vdi_cell #(
	parameter int TABLE_DEPTH = vdi_pkg::VDI_TABLE_DEPTH,
	parameter int CELL_IDX    = 0
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               advance,
	input  wire vdi_pkg::vdi_ctl_t                  in_ctl,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0]     in_idx,
	input  wire logic [vdi_pkg::VDI_VTX_W-1:0]      in_vtx,
	output vdi_pkg::vdi_ctl_t                       out_ctl,
	output logic [$clog2(TABLE_DEPTH)-1:0]          out_idx,
	output logic [vdi_pkg::VDI_VTX_W-1:0]           out_vtx
);
	import vdi_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [VDI_VTX_W-1:0] entry_q;
	logic                 entry_valid_q;
	logic                 live;
	logic                 hit;
	logic                 claim;
	vdi_ctl_t             ctl_nxt;
	logic [IDX_W-1:0]     idx_nxt;
	vdi_ctl_t             ctl_q;
	logic [IDX_W-1:0]     idx_q;
	logic [VDI_VTX_W-1:0] vtx_q;

	// A request carrying the mesh-start flag sees the entry as already empty.
	always_comb begin
		live    = entry_valid_q && !in_ctl.clear;
		hit     = in_ctl.valid && !in_ctl.found && live && (entry_q == in_vtx);
		claim   = in_ctl.valid && !in_ctl.found && !live;
		ctl_nxt = in_ctl;
		idx_nxt = in_idx;
		if (hit || claim) begin
			ctl_nxt.found  = 1'b1;
			ctl_nxt.is_new = claim;
			idx_nxt        = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
			ctl_q.valid   <= 1'b0;
			ctl_q.clear   <= 1'b0;
			ctl_q.found   <= 1'b0;
			ctl_q.is_new  <= 1'b0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
			if (claim) begin
				entry_valid_q <= 1'b1;
			end else if (in_ctl.valid && in_ctl.clear) begin
				entry_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_q <= idx_nxt;
			vtx_q <= in_vtx;
			if (claim) begin
				entry_q <= in_vtx;
			end
		end
	end

	assign out_ctl = ctl_q;
	assign out_idx = idx_q;
	assign out_vtx = vtx_q;

endmodule
`default_nettype wire
